>>> rtl/core/assert_macros.svh
// Assertion macros for the SPFA net router checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, clocked on clk, off during rst.
`define SPFA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spfa router check failed");
// Next-cycle implication.
`define SPFA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spfa router check failed");
`endif

>>> rtl/core/spfa_pkg.sv
// Types, codes and sizes shared by the SPFA net router files.
`timescale 1ns / 1ps
`default_nettype none
package spfa_pkg;
  localparam int MAX_VERTICES = 1024;
  localparam int MAX_EDGES    = 4096;
  localparam int COST_BITS    = 32;
  localparam int VW           = $clog2(MAX_VERTICES);
  localparam int EW           = $clog2(MAX_EDGES);
  localparam int PW           = EW + 1;

  localparam logic [COST_BITS-1:0] COST_MAX  = '1;
  localparam logic [PW-1:0]        PRED_NONE = '1;

  localparam logic [2:0] MODE_LOAD   = 3'd0;
  localparam logic [2:0] MODE_START  = 3'd1;
  localparam logic [2:0] MODE_PIN    = 3'd2;
  localparam logic [2:0] MODE_READ   = 3'd3;
  localparam logic [2:0] MODE_COMMIT = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNREACH = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  localparam logic [1:0] CFG_VCOUNT  = 2'd0;
  localparam logic [1:0] CFG_ECOUNT  = 2'd1;
  localparam logic [1:0] CFG_BASE    = 2'd2;
  localparam logic [1:0] CFG_PENALTY = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [11:0] edge_index;
    logic [9:0]  vertex_a;
    logic [9:0]  vertex_b;
    logic [9:0]  list_position;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] count;
    logic [11:0] sel_edge;
    logic [9:0]  end_one;
    logic [9:0]  end_two;
    logic [31:0] edge_weight;
  } out_word_t;

  typedef struct packed {
    logic [VW-1:0]        a;
    logic [VW-1:0]        b;
    logic [COST_BITS-1:0] cost;
  } edge_t;

  typedef struct packed {
    logic [COST_BITS-1:0] dcost;
    logic [PW-1:0]        pred;
    logic                 queued;
  } vtx_t;

  typedef enum logic [4:0] {
    S_CLR, S_SET, S_IDLE, S_PIN, S_INIT_RD, S_INIT_WR, S_POP, S_POP_Q, S_POP_V,
    S_SCAN_RD, S_SCAN_CHK, S_RELAX, S_POP_END, S_TR_RD, S_TR_PRED, S_TR_EDGE,
    S_RD_EDGE, S_RD_OUT, S_CM_SEL, S_CM_EDGE, S_CM_WR, S_RESP
  } state_t;
endpackage
`default_nettype wire

>>> rtl/core/spfa_if.sv
// Valid/ready channels for router request and response words.
`timescale 1ns / 1ps
`default_nettype none
interface spfa_in_if import spfa_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t word;
  modport source(output valid, output word, input ready);
  modport sink(input valid, input word, output ready);
endinterface

interface spfa_out_if import spfa_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t word;
  modport source(output valid, output word, input ready);
  modport sink(input valid, input word, output ready);
endinterface
`default_nettype wire

>>> rtl/core/spfa_steiner_net_router.sv
// SPFA Steiner net router: edge/vertex/queue/list memories and sequencer.
// Load, rejected start, bad word: respond directly. Read: list entry, then its edge.
// Commit: each list entry's edge gets the penalty added. Start net: clear all 1024
// tree entries, set pin. Add pin: init vertices, scan edges per pop, trace path.
// One word in flight; the next word is taken while a response waits at the output.
// Synchronous reset: registers to defaults, then all 1024 tree entries cleared.
`timescale 1ns / 1ps
`default_nettype none
module spfa_steiner_net_router import spfa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  spfa_in_if.sink     req,
  spfa_out_if.source  rsp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  state_t state, state_next;

  logic [10:0] vcount;
  logic [12:0] ecount;
  logic [15:0] base;
  logic [15:0] pen;

  edge_t         edge_mem [MAX_EDGES];
  vtx_t          vtx_mem  [MAX_VERTICES];
  logic          tree_mem [MAX_VERTICES];
  logic [VW-1:0] q_mem    [MAX_VERTICES];
  logic [EW-1:0] sel_mem  [MAX_VERTICES];

  edge_t edge_q, edge_wd;
  vtx_t  vtx_q, vtx_wd;
  logic  tree_q, tree_wd;
  logic [VW-1:0] q_q, q_wd;
  logic [EW-1:0] sel_q, sel_wd;
  logic edge_we, edge_re, vtx_we, vtx_re, tree_we, tree_re, q_we, q_re, sel_we, sel_re;
  logic [EW-1:0] edge_wa, edge_ra;
  logic [VW-1:0] vtx_wa, vtx_ra, tree_wa, tree_ra, q_wa, q_ra, sel_wa, sel_ra;

  in_word_t  word;
  out_word_t res;
  out_word_t out_word;
  logic      out_valid;
  logic      tree_set;
  logic [10:0] vtx;
  logic [VW-1:0] head, tail, u, other, cur;
  logic [10:0] pending, sel_total, steps, added, over, idx;
  logic [COST_BITS-1:0] du;
  logic [PW-1:0] pred_u;
  logic [12:0] e_cnt;
  logic [EW-1:0] ce;

  logic [10:0] nv;
  logic [12:0] ne;
  logic in_acc, out_free, bad_load, bad_pin, bad_pos;
  logic match_a, match_b, hit, better, push;
  logic [VW-1:0] oth;
  logic [COST_BITS:0] sum_w, cm_w;
  logic [COST_BITS-1:0] sum, cm_cost;
  logic [16:0] limit;
  logic [1:0]  st_in;

  assign nv = (vcount > 11'(MAX_VERTICES)) ? 11'(MAX_VERTICES) : vcount;
  assign ne = (ecount > 13'(MAX_EDGES)) ? 13'(MAX_EDGES) : ecount;
  assign req.ready = (state == S_IDLE);
  assign in_acc = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;
  assign rsp.valid = out_valid;
  assign rsp.word = out_word;

  assign bad_pin  = {1'b0, req.word.vertex_a} >= nv;
  assign bad_load = bad_pin || ({1'b0, req.word.vertex_b} >= nv);
  assign bad_pos  = {1'b0, req.word.list_position} >= sel_total;

  assign match_a = (edge_q.a == u);
  assign match_b = (edge_q.b == u);
  assign oth = match_a ? edge_q.b : edge_q.a;
  assign hit = (match_a || match_b) && ({1'b0, oth} < nv);
  assign sum_w = {1'b0, du} + {1'b0, edge_q.cost};
  assign sum = sum_w[COST_BITS] ? COST_MAX : sum_w[COST_BITS-1:0];
  assign better = sum < vtx_q.dcost;
  assign push = better && !vtx_q.queued && (pending < 11'(MAX_VERTICES));
  assign cm_w = {1'b0, edge_q.cost} + (COST_BITS+1)'(pen);
  assign cm_cost = cm_w[COST_BITS] ? COST_MAX : cm_w[COST_BITS-1:0];
  assign limit = {1'b0, base} + {1'b0, pen};

  always_comb begin
    case (req.word.mode)
      MODE_LOAD:   st_in = bad_load ? ST_RANGE : ST_OK;
      MODE_START:  st_in = bad_pin ? ST_RANGE : ST_OK;
      MODE_PIN:    st_in = bad_pin ? ST_RANGE : ST_OK;
      MODE_READ:   st_in = bad_pos ? ST_RANGE : ST_OK;
      MODE_COMMIT: st_in = ST_OK;
      default:     st_in = ST_RANGE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[edge_wa] <= edge_wd;
    if (edge_re) edge_q <= edge_mem[edge_ra];
    if (vtx_we) vtx_mem[vtx_wa] <= vtx_wd;
    if (vtx_re) vtx_q <= vtx_mem[vtx_ra];
    if (tree_we) tree_mem[tree_wa] <= tree_wd;
    if (tree_re) tree_q <= tree_mem[tree_ra];
    if (q_we) q_mem[q_wa] <= q_wd;
    if (q_re) q_q <= q_mem[q_ra];
    if (sel_we) sel_mem[sel_wa] <= sel_wd;
    if (sel_re) sel_q <= sel_mem[sel_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    edge_we = 1'b0; edge_re = 1'b0; edge_wa = '0; edge_ra = '0; edge_wd = '0;
    vtx_we = 1'b0;  vtx_re = 1'b0;  vtx_wa = '0;  vtx_ra = '0;  vtx_wd = '0;
    tree_we = 1'b0; tree_re = 1'b0; tree_wa = '0; tree_ra = '0; tree_wd = 1'b0;
    q_we = 1'b0;    q_re = 1'b0;    q_wa = '0;    q_ra = '0;    q_wd = '0;
    sel_we = 1'b0;  sel_re = 1'b0;  sel_wa = '0;  sel_ra = '0;  sel_wd = '0;
    unique case (state)
      S_CLR: begin
        tree_we = 1'b1;
        tree_wa = vtx[VW-1:0];
        if (vtx == 11'(MAX_VERTICES - 1)) state_next = tree_set ? S_SET : S_IDLE;
      end
      S_SET: begin
        tree_we = 1'b1;
        tree_wa = word.vertex_a;
        tree_wd = 1'b1;
        state_next = S_RESP;
      end
      S_IDLE: begin
        if (in_acc) begin
          state_next = S_RESP;
          case (req.word.mode)
            MODE_LOAD: begin
              if (!bad_load) begin
                edge_we = 1'b1;
                edge_wa = req.word.edge_index;
                edge_wd = '{a: req.word.vertex_a, b: req.word.vertex_b,
                            cost: COST_BITS'(base)};
              end
            end
            MODE_START: if (!bad_pin) state_next = S_CLR;
            MODE_PIN: begin
              if (!bad_pin) begin
                tree_re = 1'b1;
                tree_ra = req.word.vertex_a;
                state_next = S_PIN;
              end
            end
            MODE_READ: begin
              if (!bad_pos) begin
                sel_re = 1'b1;
                sel_ra = req.word.list_position;
                state_next = S_RD_EDGE;
              end
            end
            MODE_COMMIT: state_next = S_CM_SEL;
            default: state_next = S_RESP;
          endcase
        end
      end
      S_PIN: state_next = tree_q ? S_RESP : S_INIT_RD;
      S_INIT_RD: begin
        tree_re = 1'b1;
        tree_ra = vtx[VW-1:0];
        state_next = S_INIT_WR;
      end
      S_INIT_WR: begin
        vtx_we = 1'b1;
        vtx_wa = vtx[VW-1:0];
        vtx_wd = '{dcost: tree_q ? '0 : COST_MAX, pred: PRED_NONE, queued: tree_q};
        q_we = tree_q;
        q_wa = tail;
        q_wd = vtx[VW-1:0];
        state_next = (vtx == nv - 11'd1) ? S_POP : S_INIT_RD;
      end
      S_POP: begin
        if (pending == '0) state_next = S_TR_RD;
        else begin
          q_re = 1'b1;
          q_ra = head;
          state_next = S_POP_Q;
        end
      end
      S_POP_Q: begin
        vtx_re = 1'b1;
        vtx_ra = q_q;
        state_next = S_POP_V;
      end
      S_POP_V: state_next = S_SCAN_RD;
      S_SCAN_RD: begin
        if (e_cnt == ne) state_next = S_POP_END;
        else begin
          edge_re = 1'b1;
          edge_ra = e_cnt[EW-1:0];
          state_next = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (hit) begin
          vtx_re = 1'b1;
          vtx_ra = oth;
          state_next = S_RELAX;
        end else state_next = S_SCAN_RD;
      end
      S_RELAX: begin
        vtx_we = better;
        vtx_wa = other;
        vtx_wd = '{dcost: sum, pred: e_cnt, queued: vtx_q.queued || push};
        q_we = push;
        q_wa = tail;
        q_wd = other;
        state_next = S_SCAN_RD;
      end
      S_POP_END: begin
        vtx_we = 1'b1;
        vtx_wa = u;
        vtx_wd = '{dcost: du, pred: pred_u, queued: 1'b0};
        state_next = S_POP;
      end
      S_TR_RD: begin
        if (steps == nv) state_next = S_RESP;
        else begin
          vtx_re = 1'b1;
          vtx_ra = cur;
          state_next = S_TR_PRED;
        end
      end
      S_TR_PRED: begin
        if (vtx_q.pred == PRED_NONE) state_next = S_RESP;
        else begin
          tree_we = 1'b1;
          tree_wa = cur;
          tree_wd = 1'b1;
          sel_we = sel_total < 11'(MAX_VERTICES);
          sel_wa = sel_total[VW-1:0];
          sel_wd = vtx_q.pred[EW-1:0];
          edge_re = 1'b1;
          edge_ra = vtx_q.pred[EW-1:0];
          state_next = S_TR_EDGE;
        end
      end
      S_TR_EDGE: state_next = S_TR_RD;
      S_RD_EDGE: begin
        edge_re = 1'b1;
        edge_ra = sel_q;
        state_next = S_RD_OUT;
      end
      S_RD_OUT: state_next = S_RESP;
      S_CM_SEL: begin
        if (idx == sel_total) state_next = S_RESP;
        else begin
          sel_re = 1'b1;
          sel_ra = idx[VW-1:0];
          state_next = S_CM_EDGE;
        end
      end
      S_CM_EDGE: begin
        edge_re = 1'b1;
        edge_ra = sel_q;
        state_next = S_CM_WR;
      end
      S_CM_WR: begin
        edge_we = 1'b1;
        edge_wa = ce;
        edge_wd = '{a: edge_q.a, b: edge_q.b, cost: cm_cost};
        state_next = S_CM_SEL;
      end
      S_RESP: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount <= 11'd1024;
      ecount <= '0;
      base <= 16'd1;
      pen <= 16'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VCOUNT:  vcount <= cfg_data[10:0];
        CFG_ECOUNT:  ecount <= cfg_data[12:0];
        CFG_BASE:    base <= cfg_data;
        CFG_PENALTY: pen <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel_total <= '0;
      tree_set <= 1'b0;
      vtx <= '0;
    end else begin
      if (state == S_RESP && out_free) begin
        out_valid <= 1'b1;
        out_word <= res;
      end else if (rsp.ready) out_valid <= 1'b0;
      case (state)
        S_CLR: vtx <= vtx + 11'd1;
        S_SET: sel_total <= '0;
        S_IDLE: begin
          if (in_acc) begin
            word <= req.word;
            res <= '{status: st_in, count: '0, sel_edge: '0, end_one: '0,
                     end_two: '0, edge_weight: '0};
            vtx <= '0;
            idx <= '0;
            over <= '0;
            tree_set <= 1'b1;
          end
        end
        S_PIN: begin
          head <= '0;
          tail <= '0;
          pending <= '0;
          cur <= word.vertex_a;
          steps <= '0;
          added <= '0;
        end
        S_INIT_WR: begin
          vtx <= vtx + 11'd1;
          if (tree_q) begin
            tail <= tail + 1'b1;
            pending <= pending + 11'd1;
          end
        end
        S_POP_Q: u <= q_q;
        S_POP_V: begin
          du <= vtx_q.dcost;
          pred_u <= vtx_q.pred;
          e_cnt <= '0;
        end
        S_SCAN_CHK: begin
          other <= oth;
          if (!hit) e_cnt <= e_cnt + 13'd1;
        end
        S_RELAX: begin
          e_cnt <= e_cnt + 13'd1;
          if (push) begin
            tail <= tail + 1'b1;
            pending <= pending + 11'd1;
          end
        end
        S_POP_END: begin
          head <= head + 1'b1;
          pending <= pending - 11'd1;
        end
        S_TR_RD: if (steps == nv) res.count <= added;
        S_TR_PRED: begin
          if (vtx_q.pred == PRED_NONE) begin
            if (steps == '0) res.status <= ST_UNREACH;
            else res.count <= added;
          end else begin
            added <= added + 11'd1;
            if (sel_total < 11'(MAX_VERTICES)) sel_total <= sel_total + 11'd1;
          end
        end
        S_TR_EDGE: begin
          cur <= (cur != edge_q.a) ? edge_q.a : edge_q.b;
          steps <= steps + 11'd1;
        end
        S_RD_EDGE: res.sel_edge <= sel_q;
        S_RD_OUT: begin
          res.end_one <= edge_q.a;
          res.end_two <= edge_q.b;
          res.edge_weight <= edge_q.cost;
        end
        S_CM_SEL: if (idx == sel_total) res.count <= over;
        S_CM_EDGE: ce <= sel_q;
        S_CM_WR: begin
          idx <= idx + 11'd1;
          if (cm_cost > COST_BITS'(limit)) over <= over + 11'd1;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/spfa_chk.sv
// Port-level checker for the SPFA net router, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module spfa_chk import spfa_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  rsp_status,
  input logic [10:0] rsp_count,
  input logic [11:0] rsp_sel_edge,
  input logic [31:0] rsp_weight
);
  `SPFA_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
  `SPFA_ASSERT_NXT(a_one_word, req_valid && req_ready, !req_ready)
  `SPFA_ASSERT_IMP(a_status_code, rsp_valid, rsp_status != 2'd3)
  `SPFA_ASSERT_IMP(a_fail_empty, rsp_valid && rsp_status != ST_OK, rsp_count == '0 && rsp_sel_edge == '0 && rsp_weight == '0)
endmodule

bind spfa_steiner_net_router spfa_chk u_chk (
  .clk(clk),
  .rst(rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_status(rsp.word.status),
  .rsp_count(rsp.word.count),
  .rsp_sel_edge(rsp.word.sel_edge),
  .rsp_weight(rsp.word.edge_weight)
);
`default_nettype wire
